/* hw/rtl/mzs_pkg.sv */
// Shared types and fixed constants for the accelerometer magnitude / zero-span block.
// No dependencies; every module in hw/rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mzs_pkg;

  // Fixed output and scaling widths
  localparam int QBITS      = 11;            // quotient bits kept before saturation
  localparam int SCALE_MAX  = 2047;          // saturation magnitude of a scaled axis
  localparam int SQ_W       = 2 * QBITS;     // one squared axis
  localparam int SUM_W      = SQ_W + 2;      // three squared axes
  localparam int MAG_W      = SUM_W / 2;     // root width
  localparam int MAG_MAX    = 3545;          // floor root of the largest sum
  localparam int SPAN_W     = 16;
  localparam int GAP_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_AXES   = 3;

  // Calibration arithmetic constants
  localparam int SCALE_HI  = 200;
  localparam int SCALE_MID = 100;

  // Register reset values
  localparam int X_MINUS_RST = 264;
  localparam int X_PLUS_RST  = 397;
  localparam int Y_MINUS_RST = 264;
  localparam int Y_PLUS_RST  = 399;
  localparam int Z_MINUS_RST = 269;
  localparam int Z_PLUS_RST  = 404;
  localparam int GAP_RST     = 100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_MINUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_PLUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MINUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_PLUS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_MINUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_PLUS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd6;

  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] sq;
  } lane_out_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] mag;
  } root_out_t;

  typedef struct packed {
    logic              done;
    logic [SPAN_W-1:0] length;
  } span_res_t;

endpackage

`default_nettype wire

/* hw/rtl/mzs_lane.sv */
// One axis lane: calibration scaling by an 11-step restoring divider, saturation, square.
// Depends on mzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mzs_lane #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [ADC_BITS-1:0] raw,
  input  wire logic [ADC_BITS-1:0] minus,
  input  wire logic [ADC_BITS-1:0] plus,
  output mzs_pkg::lane_out_t       res
);
  import mzs_pkg::*;

  localparam int NUM_W = ADC_BITS + 8;
  localparam int REM_W = ADC_BITS + QBITS;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_PREP = 5'b00010,
    L_DIV  = 5'b00100,
    L_SQ   = 5'b01000,
    L_DONE = 5'b10000
  } lane_state_t;

  lane_state_t         st_r, st_nxt;
  logic [NUM_W-1:0]    abs_r;
  logic [ADC_BITS-1:0] d_r;
  logic                zero_r, sat_r;
  logic [REM_W-1:0]    rem_r;
  logic [QBITS-1:0]    q_r;
  logic [3:0]          i_r;
  logic [SQ_W-1:0]     sq_r;

  logic [NUM_W-1:0] pos, neg;
  logic [REM_W-1:0] trial;
  logic [QBITS-1:0] val;
  logic             last_step;

  assign pos   = NUM_W'(raw) * NUM_W'(SCALE_HI);
  assign neg   = NUM_W'(SCALE_MID) * (NUM_W'(plus) + NUM_W'(minus));
  assign trial = REM_W'(d_r) << i_r;
  assign last_step = (i_r == 4'd0);

  // q_r holds the full quotient once the last divide step is done
  always_comb begin
    if (zero_r) begin
      val = '0;
    end else if (sat_r) begin
      val = QBITS'(SCALE_MAX);
    end else begin
      val = q_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE, L_DONE: if (start) st_nxt = L_PREP;
      L_PREP:         st_nxt = L_DIV;
      L_DIV:          if (last_step) st_nxt = L_SQ;
      L_SQ:           st_nxt = L_DONE;
      default:        st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE, L_DONE: begin
        if (start) begin
          abs_r  <= (pos >= neg) ? (pos - neg) : (neg - pos);
          d_r    <= plus - minus;
          zero_r <= (plus <= minus);
        end
      end
      L_PREP: begin
        sat_r <= (REM_W'(abs_r) >= (REM_W'(d_r) << QBITS));
        rem_r <= REM_W'(abs_r);
        q_r   <= '0;
        i_r   <= 4'(QBITS - 1);
      end
      L_DIV: begin
        if (rem_r >= trial) begin
          rem_r     <= rem_r - trial;
          q_r[i_r]  <= 1'b1;
        end
        if (!last_step) i_r <= i_r - 4'd1;
      end
      // square once the last quotient bit is in
      L_SQ: sq_r <= SQ_W'(val) * SQ_W'(val);
      default: ;
    endcase
  end

  assign res.done = (st_r == L_DONE);
  assign res.sq   = sq_r;

  a_sq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (res.sq <= SQ_W'(SCALE_MAX * SCALE_MAX)))
    else $error("lane square beyond saturation bound");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == L_PREP) |=> (st_r == L_DIV && i_r == 4'(QBITS - 1)))
    else $error("divider did not start at the top quotient bit");

  a_zero_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (res.done && zero_r) |-> (res.sq == '0))
    else $error("degenerate calibration gave a nonzero square");

endmodule

`default_nettype wire

/* hw/rtl/mzs_root.sv */
// Merge stage: sums the three lane squares and takes the floor root, one result bit a cycle.
// Depends on mzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mzs_root (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  mzs_pkg::lane_out_t      lane [mzs_pkg::NUM_AXES],
  output mzs_pkg::root_out_t      res
);
  import mzs_pkg::*;

  localparam int RREM_W = MAG_W + 2;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_RUN  = 3'b010,
    R_DONE = 3'b100
  } root_state_t;

  root_state_t        st_r, st_nxt;
  logic [SUM_W-1:0]   v_r;
  logic [RREM_W-1:0]  rem_r;
  logic [MAG_W-1:0]   root_r;
  logic [3:0]         cnt_r;

  logic [RREM_W+1:0]  shifted, trial;
  logic               ge;

  assign shifted = {rem_r, v_r[SUM_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = (shifted >= trial);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      R_IDLE, R_DONE: if (start) st_nxt = R_RUN;
      R_RUN:          if (cnt_r == 4'd0) st_nxt = R_DONE;
      default:        st_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= R_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      R_IDLE, R_DONE: begin
        if (start) begin
          v_r    <= SUM_W'(lane[0].sq) + SUM_W'(lane[1].sq) + SUM_W'(lane[2].sq);
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= 4'(MAG_W - 1);
        end
      end
      R_RUN: begin
        // bring down two bits, try root*4+1
        rem_r  <= ge ? RREM_W'(shifted - trial) : RREM_W'(shifted);
        root_r <= {root_r[MAG_W-2:0], ge};
        v_r    <= v_r << 2;
        if (cnt_r != 4'd0) cnt_r <= cnt_r - 4'd1;
      end
      default: ;
    endcase
  end

  assign res.done = (st_r == R_DONE);
  assign res.mag  = root_r;

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (res.mag <= MAG_W'(MAG_MAX)))
    else $error("root beyond largest possible magnitude");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == R_RUN && cnt_r == 4'd0) |=> res.done)
    else $error("root did not finish after its last step");

endmodule

`default_nettype wire

/* hw/rtl/mzs_span.sv */
// Zero-span tracker: saturating counters since first and last zero magnitude, held length.
// Depends on mzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mzs_span #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       upd,
  input  wire logic                       mag_zero,
  input  wire logic [mzs_pkg::GAP_W-1:0]  gap_limit,
  output mzs_pkg::span_res_t              res
);
  import mzs_pkg::*;

  localparam int CMP_W = (COUNT_BITS > GAP_W) ? COUNT_BITS : GAP_W;

  logic                  counting_r, counting_nxt;
  logic [COUNT_BITS-1:0] sfz_r, sfz_nxt, sfz_inc;
  logic [COUNT_BITS-1:0] slz_r, slz_nxt, slz_inc;
  logic [COUNT_BITS-1:0] held_r, held_nxt;
  logic                  end_now;

  assign sfz_inc = (&sfz_r) ? sfz_r : sfz_r + 1'b1;
  assign slz_inc = (&slz_r) ? slz_r : slz_r + 1'b1;

  always_comb begin
    counting_nxt = counting_r;
    sfz_nxt      = sfz_r;
    slz_nxt      = slz_r;
    held_nxt     = held_r;
    end_now      = 1'b0;
    if (counting_r) begin
      sfz_nxt = sfz_inc;
      if (mag_zero) begin
        slz_nxt = '0;
      end else begin
        slz_nxt = slz_inc;
        if (CMP_W'(slz_inc) > CMP_W'(gap_limit)) begin
          held_nxt     = sfz_inc;
          counting_nxt = 1'b0;
          end_now      = 1'b1;
        end
      end
    end else if (mag_zero) begin
      // start a span, no end test on this sample
      counting_nxt = 1'b1;
      sfz_nxt      = '0;
      slz_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counting_r <= 1'b0;
      sfz_r      <= '0;
      slz_r      <= '0;
      held_r     <= '0;
    end else if (upd) begin
      counting_r <= counting_nxt;
      sfz_r      <= sfz_nxt;
      slz_r      <= slz_nxt;
      held_r     <= held_nxt;
    end
  end

  assign res.done   = end_now;
  assign res.length = SPAN_W'(held_nxt);

  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && end_now) |=> !counting_r)
    else $error("span ended but counting continues");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !counting_r |-> !end_now)
    else $error("span end reported outside a span");

endmodule

`default_nettype wire

/* hw/rtl/accel_magnitude_zero_span_top.sv */
// Accelerometer magnitude with zero-span length: a new sample is accepted only after the previous
// one has moved its result beat into the output register.
// Three lanes scale x, y, z in parallel, each through an 11-step restoring divider and a
// square step; the merge stage sums the squares and takes a 12-step bit-serial root, and the
// span tracker updates as the result enters the output register. A finished result can wait in
// the output register while the next sample is accepted; a result that finds that register
// still stalled holds the block until the waiting beat leaves. Calibration writes are taken
// while no sample is in flight.
// Depends on mzs_pkg, mzs_lane, mzs_root, mzs_span.
`timescale 1ns / 1ps
`default_nettype none

module accel_magnitude_zero_span_top #(
  parameter int ADC_BITS   = 10,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [ADC_BITS-1:0]             in_x_raw,
  input  wire logic [ADC_BITS-1:0]             in_y_raw,
  input  wire logic [ADC_BITS-1:0]             in_z_raw,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [mzs_pkg::MAG_W-1:0]       out_magnitude,
  output      logic                            out_span_done,
  output      logic [mzs_pkg::SPAN_W-1:0]      out_span_length,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [mzs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mzs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mzs_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_LANE = 3'b010,
    T_ROOT = 3'b100
  } top_state_t;

  top_state_t          state_r, state_nxt;
  logic [ADC_BITS-1:0] minus_r [NUM_AXES];
  logic [ADC_BITS-1:0] plus_r  [NUM_AXES];
  logic [GAP_W-1:0]    gap_r;
  logic                out_valid_r;
  logic [MAG_W-1:0]    out_mag_r;
  logic                out_done_r;
  logic [SPAN_W-1:0]   out_len_r;

  logic [ADC_BITS-1:0] lane_raw [NUM_AXES];
  lane_out_t           lane_res [NUM_AXES];
  root_out_t           root_res;
  span_res_t           span_res;
  logic                in_take, lanes_done, root_start, finish, out_free;

  assign in_take    = in_valid && !in_stall;
  assign lanes_done = lane_res[0].done && lane_res[1].done && lane_res[2].done;
  assign root_start = (state_r == T_LANE) && lanes_done;
  assign out_free   = !out_valid_r || !out_stall;
  assign finish     = (state_r == T_ROOT) && root_res.done && out_free;

  assign lane_raw[0] = in_x_raw;
  assign lane_raw[1] = in_y_raw;
  assign lane_raw[2] = in_z_raw;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minus_r[0] <= ADC_BITS'(X_MINUS_RST);
      plus_r[0]  <= ADC_BITS'(X_PLUS_RST);
      minus_r[1] <= ADC_BITS'(Y_MINUS_RST);
      plus_r[1]  <= ADC_BITS'(Y_PLUS_RST);
      minus_r[2] <= ADC_BITS'(Z_MINUS_RST);
      plus_r[2]  <= ADC_BITS'(Z_PLUS_RST);
      gap_r      <= GAP_W'(GAP_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_MINUS: minus_r[0] <= cfg_data[ADC_BITS-1:0];
        REG_X_PLUS:  plus_r[0]  <= cfg_data[ADC_BITS-1:0];
        REG_Y_MINUS: minus_r[1] <= cfg_data[ADC_BITS-1:0];
        REG_Y_PLUS:  plus_r[1]  <= cfg_data[ADC_BITS-1:0];
        REG_Z_MINUS: minus_r[2] <= cfg_data[ADC_BITS-1:0];
        REG_Z_PLUS:  plus_r[2]  <= cfg_data[ADC_BITS-1:0];
        REG_GAP:     gap_r      <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE:  if (in_take) state_nxt = T_LANE;
      T_LANE:  if (lanes_done) state_nxt = T_ROOT;
      T_ROOT:  if (finish) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // load the output beat, hold it while stalled
  always_ff @(posedge clk) begin
    if (finish) begin
      out_mag_r  <= root_res.mag;
      out_done_r <= span_res.done;
      out_len_r  <= span_res.length;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    mzs_lane #(
      .ADC_BITS(ADC_BITS)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .start(in_take),
      .raw  (lane_raw[g]),
      .minus(minus_r[g]),
      .plus (plus_r[g]),
      .res  (lane_res[g])
    );
  end

  mzs_root u_root (
    .clk  (clk),
    .rst_n(rst_n),
    .start(root_start),
    .lane (lane_res),
    .res  (root_res)
  );

  mzs_span #(
    .COUNT_BITS(COUNT_BITS)
  ) u_span (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (finish),
    .mag_zero (root_res.mag == '0),
    .gap_limit(gap_r),
    .res      (span_res)
  );

  assign in_stall        = (state_r != T_IDLE);
  assign cfg_ready       = (state_r == T_IDLE);
  assign out_valid       = out_valid_r;
  assign out_magnitude   = out_mag_r;
  assign out_span_done   = out_done_r;
  assign out_span_length = out_len_r;

  a_out_from_root: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_ROOT && root_res.done))
    else $error("result beat appeared without a finished root");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_ROOT) |-> lanes_done)
    else $error("lanes out of step during root");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == T_LANE && !lanes_done))
    else $error("accepted beat did not launch the lanes");

endmodule

`default_nettype wire
